>>> rtl/core/cbba_pkg.sv
// cbba_pkg: transaction types, operation and status codes and shared widths
// for the contiguous bitmap block allocator. Depends on nothing.
package cbba_pkg;

    localparam int FUNC_W  = 2;
    localparam int BLOCK_W = 10;
    localparam int LEN_W   = 11;
    localparam int CHUNK_W = 8;   // bits the run unit walks per cycle

    localparam logic [FUNC_W-1:0] FUNC_FIND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_USE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_NONE = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [BLOCK_W-1:0] start_block;
        logic [LEN_W-1:0]   run_length;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [BLOCK_W-1:0] found_block;
    } resp_t;

    // Running state of the free-run search, carried between chunks
    typedef struct packed {
        logic               found;
        logic [LEN_W-1:0]   count;
        logic [BLOCK_W-1:0] first_blk;
    } run_state_t;

endpackage

>>> rtl/core/cbba_ram.sv
// cbba_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/cbba_run_unit.sv
// cbba_run_unit: advances the free-run search over one chunk of bitmap bits.
// Depends on cbba_pkg.
module cbba_run_unit
    import cbba_pkg::*;
(
    input  run_state_t         cur,
    input  logic [CHUNK_W-1:0] bits,     // 1 = used
    input  logic [CHUNK_W-1:0] in_range, // 1 = block exists
    input  logic [BLOCK_W-1:0] base,     // low bits of first block number
    input  logic [LEN_W-1:0]   len,
    output run_state_t         nxt
);

    always_comb
    begin
        nxt = cur;
        for (int k = 0; k < CHUNK_W; k++)
        begin
            if (!nxt.found)
            begin
                if (!bits[k] && in_range[k])
                begin
                    if (nxt.count == '0)
                    begin
                        nxt.first_blk = base + BLOCK_W'(k);
                    end
                    nxt.count = nxt.count + LEN_W'(1);
                    if (nxt.count == len)
                    begin
                        nxt.found = 1'b1;
                    end
                end
                else
                begin
                    nxt.count = '0;
                end
            end
        end
    end

endmodule

>>> rtl/core/contiguous_bitmap_block_allocator.sv
// contiguous_bitmap_block_allocator: top level, sequencer around the bitmap
// RAM and the chunk run unit. Depends on cbba_pkg, cbba_ram, cbba_run_unit.
//
// Usage
//   req (valid/ready) carries func, start_block and run_length; resp
//   (valid/ready) returns status and found_block, one per request.
//   The bitmap sits in a RAM of WORD_W-bit words, one bit per block.
//   Find: each word is read in S_FRD and checked in S_FCHK, at once if the
//   word is wholly free or wholly used, otherwise chunk by chunk, 8 bits at
//   a time, by the run unit; it stops at the first word that completes the
//   run. Mark used/free: a read-modify-write (S_MRD, then S_MWR) of each
//   word the run touches; S_DONE hands the result to the output register.
//   The block takes one request at a time; req_ready is high only when idle,
//   and it takes a new request while an earlier result still waits in the
//   output register. A stalled receiver holds the result; a finished
//   transaction then waits for the slot to drain.
//   After reset a clearing pass writes every RAM word to free while
//   req_ready is low.
//   WORD_W must be a power of two and at least 8.
module contiguous_bitmap_block_allocator
    import cbba_pkg::*;
#(
    parameter int BLOCKS = 1024,
    parameter int WORD_W = 32
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  req_t  req,
    output logic  resp_valid,
    input  logic  resp_ready,
    output resp_t resp
);

    localparam int WORDS  = (BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int OFF_W  = $clog2(WORD_W);
    localparam int CPW    = WORD_W / CHUNK_W;
    localparam int CI_W   = (CPW > 1) ? $clog2(CPW) : 1;
    localparam int GB_W   = AW + OFF_W + 1;
    localparam int E_W    = $clog2(BLOCKS + (1 << LEN_W));
    localparam int SUM_W  = $clog2((1 << LEN_W) + WORD_W);
    localparam int CSH    = $clog2(CHUNK_W);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_FRD   = 7'b0000100,
        S_FCHK  = 7'b0001000,
        S_MRD   = 7'b0010000,
        S_MWR   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      word_reg, word_next;
    logic [CI_W-1:0]    chunk_reg, chunk_next;
    run_state_t         run_reg, run_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               set_reg, set_next;
    logic [AW-1:0]      first_word_reg, first_word_next;
    logic [AW-1:0]      last_word_reg, last_word_next;
    logic [OFF_W-1:0]   start_off_reg, start_off_next;
    logic [OFF_W-1:0]   last_off_reg, last_off_next;
    resp_t              result_reg, result_next;
    logic               resp_valid_reg, resp_valid_next;
    resp_t              resp_reg, resp_next;

    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr;
    logic [WORD_W-1:0]  wr_data, rd_data;

    logic [E_W-1:0]     start_ext, end_raw, end_cl, last_idx;
    logic [GB_W-1:0]    word_base, chunk_base;
    logic               word_full;
    logic [CHUNK_W-1:0] chunk_bits, chunk_in_range;
    run_state_t         run_chunk;
    logic [OFF_W-1:0]   lo_off, hi_off;
    logic [WORD_W-1:0]  mask;

    cbba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS),
        .ADDR_W(AW)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(word_reg),
        .rd_data(rd_data)
    );

    // Geometry of the word and chunk under the search
    assign word_base  = GB_W'({word_reg, {OFF_W{1'b0}}});
    assign chunk_base = word_base + GB_W'({chunk_reg, {CSH{1'b0}}});
    assign word_full  = (word_base + GB_W'(WORD_W)) <= GB_W'(BLOCKS);
    assign chunk_bits = rd_data[chunk_reg * CHUNK_W +: CHUNK_W];

    always_comb
    begin
        for (int k = 0; k < CHUNK_W; k++)
        begin
            chunk_in_range[k] = (chunk_base + GB_W'(k)) < GB_W'(BLOCKS);
        end
    end

    cbba_run_unit u_run (
        .cur     (run_reg),
        .bits    (chunk_bits),
        .in_range(chunk_in_range),
        .base    (BLOCK_W'(chunk_base)),
        .len     (len_reg),
        .nxt     (run_chunk)
    );

    // Mark run bounds, clipped to the bitmap
    assign start_ext = E_W'(req.start_block);
    assign end_raw   = start_ext + E_W'(req.run_length);
    assign end_cl    = (end_raw > E_W'(BLOCKS)) ? E_W'(BLOCKS) : end_raw;
    assign last_idx  = end_cl - E_W'(1);

    assign lo_off = (word_reg == first_word_reg) ? start_off_reg : '0;
    assign hi_off = (word_reg == last_word_reg)  ? last_off_reg  : '1;

    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            mask[b] = (OFF_W'(b) >= lo_off) && (OFF_W'(b) <= hi_off);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        chunk_next      = chunk_reg;
        run_next        = run_reg;
        len_next        = len_reg;
        set_next        = set_reg;
        first_word_next = first_word_reg;
        last_word_next  = last_word_reg;
        start_off_next  = start_off_reg;
        last_off_next   = last_off_reg;
        result_next     = result_reg;
        resp_valid_next = resp_valid_reg && !resp_ready;
        resp_next       = resp_reg;
        wr_en           = 1'b0;
        wr_addr         = word_reg;
        wr_data         = '0;
        rd_en           = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                if (word_reg == AW'(WORDS - 1))
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    len_next    = req.run_length;
                    result_next = '{status: STATUS_OK, found_block: req.start_block};
                    unique case (req.func)
                        FUNC_FIND:
                        begin
                            run_next  = '0;
                            word_next = '0;
                            if (req.run_length == '0)
                            begin
                                result_next = '{status: STATUS_NONE, found_block: '0};
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FRD;
                            end
                        end
                        FUNC_USE, FUNC_FREE:
                        begin
                            set_next        = (req.func == FUNC_USE);
                            word_next       = AW'(start_ext >> OFF_W);
                            first_word_next = AW'(start_ext >> OFF_W);
                            last_word_next  = AW'(last_idx >> OFF_W);
                            start_off_next  = start_ext[OFF_W-1:0];
                            last_off_next   = last_idx[OFF_W-1:0];
                            // empty or wholly out of range runs change nothing
                            state_next = (start_ext < end_cl) ? S_MRD : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_FRD:
            begin
                rd_en      = 1'b1;
                chunk_next = '0;
                state_next = S_FCHK;
            end

            S_FCHK:
            begin
                priority if (chunk_reg == '0 && word_full && rd_data == '0 &&
                             (SUM_W'(run_reg.count) + SUM_W'(WORD_W)) >= SUM_W'(len_reg))
                begin
                    // free word completes the run
                    result_next.status      = STATUS_OK;
                    result_next.found_block = (run_reg.count == '0) ?
                                              BLOCK_W'(word_base) : run_reg.first_blk;
                    state_next = S_DONE;
                end
                else if (chunk_reg == '0 && word_full && rd_data == '0)
                begin
                    if (run_reg.count == '0)
                    begin
                        run_next.first_blk = BLOCK_W'(word_base);
                    end
                    run_next.count = run_reg.count + LEN_W'(WORD_W);
                    state_next     = (word_reg == AW'(WORDS - 1)) ? S_DONE : S_FRD;
                    word_next      = word_reg + AW'(1);
                    result_next    = '{status: STATUS_NONE, found_block: '0};
                end
                else if (chunk_reg == '0 && rd_data == '1)
                begin
                    run_next.count = '0;
                    state_next     = (word_reg == AW'(WORDS - 1)) ? S_DONE : S_FRD;
                    word_next      = word_reg + AW'(1);
                    result_next    = '{status: STATUS_NONE, found_block: '0};
                end
                else
                begin
                    run_next = run_chunk;
                    if (run_chunk.found)
                    begin
                        result_next = '{status: STATUS_OK, found_block: run_chunk.first_blk};
                        state_next  = S_DONE;
                    end
                    else if (chunk_reg == CI_W'(CPW - 1))
                    begin
                        state_next  = (word_reg == AW'(WORDS - 1)) ? S_DONE : S_FRD;
                        word_next   = word_reg + AW'(1);
                        result_next = '{status: STATUS_NONE, found_block: '0};
                    end
                    else
                    begin
                        chunk_next = chunk_reg + CI_W'(1);
                    end
                end
            end

            S_MRD:
            begin
                rd_en      = 1'b1;
                state_next = S_MWR;
            end

            S_MWR:
            begin
                wr_en   = 1'b1;
                wr_data = set_reg ? (rd_data | mask) : (rd_data & ~mask);
                if (word_reg == last_word_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    word_next  = word_reg + AW'(1);
                    state_next = S_MRD;
                end
            end

            S_DONE:
            begin
                if (!resp_valid_reg || resp_ready)
                begin
                    resp_valid_next = 1'b1;
                    resp_next       = result_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            word_reg       <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            word_reg       <= word_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chunk_reg      <= chunk_next;
        run_reg        <= run_next;
        len_reg        <= len_next;
        set_reg        <= set_next;
        first_word_reg <= first_word_next;
        last_word_reg  <= last_word_next;
        start_off_reg  <= start_off_next;
        last_off_reg   <= last_off_next;
        result_reg     <= result_next;
        resp_reg       <= resp_next;
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

    // a search never writes the bitmap
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRD || state_reg == S_FCHK) |-> !wr_en)
        else $error("bitmap written during a find");

    // reaching the asked length ends the search, so the count stays below it
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FCHK) |-> (run_reg.count < len_reg))
        else $error("run count reached length without ending the search");

    // every word visited by a mark has at least one bit in its mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MWR) |-> (mask != '0))
        else $error("mark write with empty mask");

    // results appear only from the hand-off state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside hand-off");

endmodule

>>> bench/tb_contiguous_bitmap_block_allocator.sv
// Self-checking bench for contiguous_bitmap_block_allocator: drives find, mark-used and
// mark-free requests with random idle on both channels and checks every response.
// Depends on cbba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_contiguous_bitmap_block_allocator;
    import cbba_pkg::*;

    localparam int BLOCKS      = 1024;
    localparam int WD_LIMIT    = 3000;   // cycles with no transaction on either side
    localparam int TAIL_CYCLES = 200;    // longest find scan plus output slack

    // operation code the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        req_t  rq;
        resp_t rs;
    } exp_entry_t;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  req_valid  = 1'b0;
    logic  req_ready;
    req_t  req        = '0;
    logic  resp_valid;
    logic  resp_ready = 1'b0;
    resp_t resp;

    // predicted occupancy, one bit per block, 1 = used
    logic [BLOCKS-1:0] occ_map = '0;
    exp_entry_t        pending_resp_q[$];
    int                alloc_start_q[$];
    int                alloc_len_q[$];

    int err_count   = 0;
    int wd_count    = 0;
    int stall_left  = 0;
    int n_find_hit  = 0;
    int n_find_miss = 0;
    int n_mark      = 0;
    int n_unused    = 0;
    int n_resp      = 0;
    bit send_idle   = 1'b1;
    bit recv_idle   = 1'b1;

    contiguous_bitmap_block_allocator #(
        .BLOCKS (BLOCKS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 8);
        else if (r < 90)
            return $urandom_range(9, 64);
        else if (r < 98)
            return $urandom_range(65, 512);
        else
            return $urandom_range(513, 1100);
    endfunction

    function automatic req_t make_req(input logic [FUNC_W-1:0] f, input int sb, input int len);
        req_t r;
        r.func        = f;
        r.start_block = sb[BLOCK_W-1:0];
        r.run_length  = len[LEN_W-1:0];
        return r;
    endfunction

    // First-fit search and run marking on the predicted bitmap
    function automatic resp_t alloc_predict(input req_t r);
        resp_t o;
        int    cnt;
        int    first_i;
        int    i;
        int    idx;
        bit    hit;
        o.status      = STATUS_OK;
        o.found_block = r.start_block;
        case (r.func)
            FUNC_FIND:
            begin
                o.status      = STATUS_NONE;
                o.found_block = '0;
                cnt     = 0;
                first_i = 0;
                hit     = 1'b0;
                if (r.run_length != 0)
                begin
                    for (i = 0; i < BLOCKS && !hit; i++)
                    begin
                        if (!occ_map[i])
                        begin
                            if (cnt == 0)
                                first_i = i;
                            cnt++;
                            if (cnt == int'(r.run_length))
                            begin
                                hit           = 1'b1;
                                o.status      = STATUS_OK;
                                o.found_block = first_i[BLOCK_W-1:0];
                            end
                        end
                        else
                            cnt = 0;
                    end
                end
            end
            FUNC_USE, FUNC_FREE:
            begin
                for (i = 0; i < int'(r.run_length); i++)
                begin
                    idx = int'(r.start_block) + i;
                    if (idx >= BLOCKS)
                        break;
                    occ_map[idx] = (r.func == FUNC_USE);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input exp_entry_t e, input resp_t got);
        $display({"[%0t] mismatch %s: func=%0d start=%0d len=%0d",
                  " exp status=%0d block=%0d got status=%0d block=%0d"},
                 $time, what, e.rq.func, e.rq.start_block, e.rq.run_length,
                 e.rs.status, e.rs.found_block, got.status, got.found_block);
        err_count++;
    endtask

    // Present one request, wait for its transaction, record the expected response
    task automatic send_req(input req_t item, output resp_t predicted);
        int         gap;
        exp_entry_t e;
        gap = send_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = alloc_predict(item);
        e.rq = item;
        e.rs = predicted;
        pending_resp_q.push_back(e);
        if (item.func == FUNC_FIND)
        begin
            if (predicted.status == STATUS_OK)
                n_find_hit++;
            else
                n_find_miss++;
        end
        else if (item.func == FUNC_UNUSED)
            n_unused++;
        else
            n_mark++;
    endtask

    task automatic send_noise();
        resp_t got;
        int    len;
        if ($urandom_range(0, 99) < 70)
            len = $urandom_range(0, 16);
        else
            len = $urandom_range(0, 2047);
        send_req(make_req(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 1023), len), got);
    endtask

    task automatic test_directed_edges();
        resp_t got;
        send_req(make_req(FUNC_FIND,   0,    0),    got);
        send_req(make_req(FUNC_FIND,   1023, 1),    got);
        send_req(make_req(FUNC_FIND,   0,    1024), got);
        send_req(make_req(FUNC_FIND,   0,    1025), got);
        send_req(make_req(FUNC_FIND,   1023, 2047), got);
        send_req(make_req(FUNC_USE,    1023, 0),    got);
        send_req(make_req(FUNC_UNUSED, 1023, 2047), got);
        send_req(make_req(FUNC_FIND,   0,    1024), got);
        // run that would overrun the last block
        send_req(make_req(FUNC_USE,    1020, 10),   got);
        send_req(make_req(FUNC_FIND,   0,    1020), got);
        send_req(make_req(FUNC_FIND,   0,    1021), got);
        send_req(make_req(FUNC_USE,    1023, 2047), got);
        send_req(make_req(FUNC_FREE,   0,    1024), got);
        send_req(make_req(FUNC_USE,    0,    8),    got);
        send_req(make_req(FUNC_USE,    9,    7),    got);
        send_req(make_req(FUNC_FIND,   0,    1),    got);
        send_req(make_req(FUNC_FIND,   0,    2),    got);
        // only the last block left free
        send_req(make_req(FUNC_USE,    0,    1023), got);
        send_req(make_req(FUNC_FIND,   0,    1),    got);
        send_req(make_req(FUNC_FIND,   0,    2),    got);
        send_req(make_req(FUNC_FREE,   512,  1),    got);
        send_req(make_req(FUNC_FIND,   0,    1),    got);
        send_req(make_req(FUNC_FREE,   0,    2047), got);
        send_req(make_req(FUNC_FREE,   1023, 0),    got);
    endtask

    // Allocate via find then mark used; free earlier allocations; some noise
    task automatic test_alloc_churn(input int n_items);
        resp_t got;
        int    sent;
        int    pick;
        int    idx;
        int    len;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || (alloc_start_q.size() == 0 && pick < 80))
            begin
                len = pick_len();
                send_req(make_req(FUNC_FIND, $urandom_range(0, 1023), len), got);
                sent++;
                if (got.status == STATUS_OK)
                begin
                    send_req(make_req(FUNC_USE, int'(got.found_block), len), got);
                    sent++;
                    alloc_start_q.push_back(int'(got.found_block));
                    alloc_len_q.push_back(len);
                end
            end
            else if (pick < 80)
            begin
                idx = $urandom_range(0, alloc_start_q.size() - 1);
                send_req(make_req(FUNC_FREE, alloc_start_q[idx], alloc_len_q[idx]), got);
                sent++;
                alloc_start_q.delete(idx);
                alloc_len_q.delete(idx);
            end
            else
            begin
                send_noise();
                sent++;
            end
        end
    endtask

    // Scattered short used runs so that finds cross chunk and word boundaries
    task automatic test_fragmented(input int n_items);
        resp_t got;
        int    i;
        int    pick;
        send_req(make_req(FUNC_FREE, 0, BLOCKS), got);
        alloc_start_q.delete();
        alloc_len_q.delete();
        for (i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_req(make_req(FUNC_USE, $urandom_range(0, 1023), $urandom_range(1, 6)), got);
            else if (pick < 45)
                send_req(make_req(FUNC_FREE, $urandom_range(0, 1023), $urandom_range(1, 12)),
                         got);
            else
                send_req(make_req(FUNC_FIND, $urandom_range(0, 1023), $urandom_range(1, 48)),
                         got);
        end
    endtask

    task automatic test_noise(input int n_items);
        int i;
        for (i = 0; i < n_items; i++)
            send_noise();
    endtask

    task automatic test_back_to_back(input int n_items);
        resp_t got;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_req(make_req(FUNC_FREE, 0, BLOCKS), got);
        alloc_start_q.delete();
        alloc_len_q.delete();
        test_alloc_churn(n_items);
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // Response side: random back-pressure and in-order check
    always @(posedge clk)
    begin : resp_check
        exp_entry_t e;
        if (rst_n && resp_valid && resp_ready)
        begin
            n_resp++;
            if (pending_resp_q.size() == 0)
            begin
                e = '0;
                report_mismatch("response with nothing pending", e, resp);
            end
            else
            begin
                e = pending_resp_q.pop_front();
                if (resp.status !== e.rs.status)
                    report_mismatch("status", e, resp);
                if (resp.found_block !== e.rs.found_block)
                    report_mismatch("found_block", e, resp);
            end
        end
        if (recv_idle && stall_left > 0)
        begin
            resp_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            resp_ready <= 1'b1;
            if (recv_idle)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (resp_valid && resp_ready))
            wd_count <= 0;
        else
        begin
            wd_count <= wd_count + 1;
            if (wd_count >= WD_LIMIT)
            begin
                $display("[%0t] watchdog: no transaction for %0d cycles, %0d responses pending",
                         $time, WD_LIMIT, pending_resp_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_alloc_churn(1100);
        test_fragmented(350);
        test_noise(350);
        test_back_to_back(150);

        req_valid <= 1'b0;
        while (pending_resp_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d responses: %0d finds hit, %0d finds missed, %0d marks, %0d unused ops",
                 n_resp, n_find_hit, n_find_miss, n_mark, n_unused);
        $display("Idle gaps on both channels plus one back-to-back stretch; %0d errors", err_count);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
